>>> rtl/qtcb_pkg.sv
// ----------------------------------------------------------------------------
// qtcb_pkg
// Shared types and constants for the quadtree cell binning block.
// ----------------------------------------------------------------------------
package qtcb_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;
  localparam logic [1:0] REG_HEIGHT   = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [15:0]        object_id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [22:0]        radius;
  } item_t;

  typedef struct packed {
    logic [15:0] found_id;
    logic        has_object;
    logic        last;
    logic [1:0]  status;
    logic [10:0] cells_touched;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture item, zero counters
    logic scan_step;  // evaluate one axis index of the span search
    logic cell_step;  // one cell of an add or one slot of a query
    logic clr_step;   // clear one fill entry
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic cell_done;
    logic clr_done;
  } dp_stat_t;

endpackage

>>> rtl/qtcb_ram.sv
// ----------------------------------------------------------------------------
// qtcb_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module qtcb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/qtcb_datapath.sv
// ----------------------------------------------------------------------------
// qtcb_datapath
// Span search over columns and rows, fill table, id memory and result build.
// ----------------------------------------------------------------------------
module qtcb_datapath #(
  parameter int LEVELS        = 3,
  parameter int CELL_CAPACITY = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [23:0]             cfg_data,
  input  qtcb_pkg::item_t         item,
  input  qtcb_pkg::dp_cmd_t       cmd,
  output qtcb_pkg::dp_stat_t      stat,
  output logic                    res_valid,
  output qtcb_pkg::result_t       res
);

  localparam int LV    = (LEVELS < 5) ? LEVELS : 5;
  localparam int CAP   = (CELL_CAPACITY < 32) ? CELL_CAPACITY : 32;
  localparam int SIDE  = 1 << LV;
  localparam int NC    = SIDE * SIDE;
  localparam int AW    = (LV > 0) ? LV : 1;
  localparam int CW    = (2 * LV > 0) ? 2 * LV : 1;
  localparam int SW    = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int FW    = $clog2(CAP + 1);
  localparam int MAW   = CW + SW;
  localparam int SCW   = $clog2(SIDE + 1);

  // configuration registers
  logic signed [23:0] origin_x, origin_y;
  logic [22:0]        region_width, region_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      region_width  <= 23'd65536;
      region_height <= 23'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qtcb_pkg::REG_ORIGIN_X: origin_x      <= cfg_data;
        qtcb_pkg::REG_ORIGIN_Y: origin_y      <= cfg_data;
        qtcb_pkg::REG_WIDTH:    region_width  <= cfg_data[22:0];
        qtcb_pkg::REG_HEIGHT:   region_height <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // captured item, scaled extents relative to origin (exact, 31 bits plus sign)
  qtcb_pkg::item_t it;
  logic signed [31:0] xlo, xhi, ylo, yhi;   // add extent; query uses xhi/yhi as point
  logic signed [31:0] ax, ay;               // running left edge of span
  logic [SCW-1:0]     sidx;                 // axis index under scan
  logic [SIDE-1:0]    colhit, rowhit;
  logic [CW:0]        walk;                 // add walk step, one past the last cell
  logic [CW-1:0]      wcell;                // cell whose fill is read this step
  logic               pv;                   // cell read last step is overlapped
  logic [CW-1:0]      pcell;                // cell updated this step
  logic [CW-1:0]      qcell;                // cell holding the query point
  logic [SW:0]        slot;                 // query slot counter
  logic [10:0]        touched;
  logic               full;
  logic [FW-1:0]      nq;                   // fill of the queried cell

  logic signed [31:0] lx_s, hx_s, ly_s, hy_s;
  always_comb begin
    lx_s = ((32'(item.pos_x) - 32'($signed({1'b0, item.radius}))) <<< LV)
           - (32'(origin_x) <<< LV);
    hx_s = ((32'(item.pos_x) + 32'($signed({1'b0, item.radius}))) <<< LV)
           - (32'(origin_x) <<< LV);
    ly_s = ((32'(item.pos_y) - 32'($signed({1'b0, item.radius}))) <<< LV)
           - (32'(origin_y) <<< LV);
    hy_s = ((32'(item.pos_y) + 32'($signed({1'b0, item.radius}))) <<< LV)
           - (32'(origin_y) <<< LV);
  end

  // span test for index sidx on both axes: lo <= right && hi > left
  logic signed [31:0] rx, ry;
  logic               hitx, hity;
  always_comb begin
    rx   = ax + 32'($signed({1'b0, region_width}));
    ry   = ay + 32'($signed({1'b0, region_height}));
    hitx = (xlo <= rx) && (xhi > ax);
    hity = (ylo <= ry) && (yhi > ay);
  end

  // fill counts in memory, cleared by the sweep after reset and by clear
  logic          fill_we;
  logic [CW-1:0] fill_waddr, fill_raddr;
  logic [FW-1:0] fill_wdata, fill_rdata;
  logic [CW-1:0] clr_idx;

  // walk position decode (row-major)
  logic [AW-1:0] crow, ccol;
  logic          cell_hit;
  logic          walk_end;
  always_comb begin
    wcell    = walk[CW-1:0];
    crow     = AW'(wcell >> LV);
    ccol     = AW'(wcell);
    cell_hit = rowhit[crow] && colhit[ccol];
    walk_end = (32'(walk) == NC);
  end

  // update stage of the add walk, fill data arrives on the step after the read
  logic is_add;
  logic pfree;
  logic add_wr;
  always_comb begin
    is_add = (it.op == qtcb_pkg::OP_ADD);
    pfree  = (32'(fill_rdata) < CAP);
    add_wr = cmd.cell_step && is_add && pv && pfree;
  end

  // id memory
  logic           ram_we;
  logic [MAW-1:0] ram_waddr, ram_raddr;
  logic [15:0]    ram_rdata;

  always_comb begin
    ram_we    = add_wr;
    ram_waddr = MAW'({pcell, SW'(fill_rdata)});
    ram_raddr = MAW'({qcell, SW'(slot)});
  end

  // fill memory ports
  always_comb begin
    fill_we    = add_wr || cmd.clr_step;
    fill_waddr = cmd.clr_step ? clr_idx : pcell;
    fill_wdata = cmd.clr_step ? '0 : fill_rdata + 1'b1;
    fill_raddr = is_add ? wcell : qcell;
  end

  qtcb_ram #(.WIDTH(16), .DEPTH(1 << MAW)) u_ids (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (it.object_id),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  qtcb_ram #(.WIDTH(FW), .DEPTH(1 << CW)) u_fill (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  // index of first set bit, used for query point cell
  function automatic logic [AW-1:0] first_bit(input logic [SIDE-1:0] v);
    logic [AW-1:0] r;
    r = '0;
    for (int i = SIDE - 1; i >= 0; i--) begin
      if (v[i]) r = AW'(i);
    end
    return r;
  endfunction

  // query cell is fixed once the scan ends, so its fill read is ready in time
  logic qinside;
  always_comb begin
    qcell   = CW'({first_bit(rowhit), first_bit(colhit)});
    qinside = (|rowhit) && (|colhit);
    nq      = fill_rdata;
  end

  // result strobe sources
  logic q_empty;   // query gives its single empty or outside result
  logic q_issue;   // query reads one more slot
  logic add_last;
  logic clr_last;
  always_comb begin
    q_empty  = cmd.cell_step && !is_add && (!qinside || nq == '0);
    q_issue  = cmd.cell_step && !is_add && !q_empty && (32'(slot) < 32'(nq));
    add_last = cmd.cell_step && is_add && walk_end;
    clr_last = cmd.clr_step && (32'(clr_idx) == NC - 1);
  end

  logic rd_pend;   // id read data valid this cycle
  logic rd_lastf;

  always_ff @(posedge clk) begin
    if (rst) begin
      it        <= '0;
      res_valid <= 1'b0;
      rd_pend   <= 1'b0;
      pv        <= 1'b0;
      clr_idx   <= '0;
    end else begin
      res_valid <= add_last || q_empty || rd_pend ||
                   (clr_last && it.op == qtcb_pkg::OP_CLEAR);
      rd_pend   <= q_issue;
      // capture
      if (cmd.load) begin
        it      <= item;
        sidx    <= '0;
        ax      <= '0;
        ay      <= '0;
        walk    <= '0;
        pv      <= 1'b0;
        slot    <= '0;
        touched <= '0;
        full    <= 1'b0;
        clr_idx <= '0;
        if (item.op == qtcb_pkg::OP_QUERY) begin
          xlo <= (32'(item.pos_x) <<< LV) - (32'(origin_x) <<< LV);
          ylo <= (32'(item.pos_y) <<< LV) - (32'(origin_y) <<< LV);
          xhi <= (32'(item.pos_x) <<< LV) - (32'(origin_x) <<< LV);
          yhi <= (32'(item.pos_y) <<< LV) - (32'(origin_y) <<< LV);
        end else begin
          xlo <= lx_s;
          xhi <= hx_s;
          ylo <= ly_s;
          yhi <= hy_s;
        end
      end
      // one axis index per cycle
      if (cmd.scan_step) begin
        if (is_add) begin
          colhit[AW'(sidx)] <= hitx;
          rowhit[AW'(sidx)] <= hity;
        end else begin
          // point inside (a, a+w]: dx > a && dx <= a+w
          colhit[AW'(sidx)] <= (xhi > ax) && (xhi <= rx);
          rowhit[AW'(sidx)] <= (yhi > ay) && (yhi <= ry);
        end
        ax   <= rx;
        ay   <= ry;
        sidx <= sidx + 1'b1;
      end
      // add: read one cell's fill per step, update it on the next step
      if (cmd.cell_step && is_add) begin
        pv    <= cell_hit && !walk_end;
        pcell <= wcell;
        if (!walk_end) walk <= walk + 1'b1;
        if (pv) begin
          if (pfree) begin
            touched <= touched + 1'b1;
          end else begin
            full <= 1'b1;
          end
        end
        if (walk_end) begin
          res.found_id           <= '0;
          res.has_object         <= 1'b0;
          res.last               <= 1'b1;
          res.cells_touched      <= touched + 11'((pv && pfree) ? 1 : 0);
          if (full || (pv && !pfree))
            res.status <= qtcb_pkg::ST_FULL;
          else if ((|rowhit) && (|colhit))
            res.status <= qtcb_pkg::ST_OK;
          else
            res.status <= qtcb_pkg::ST_OUTSIDE;
        end
      end
      // query: one slot read per cycle; the id goes via rd_pend to the result register
      if (q_empty) begin
        res.found_id      <= '0;
        res.has_object    <= 1'b0;
        res.last          <= 1'b1;
        res.status        <= qinside ? qtcb_pkg::ST_OK : qtcb_pkg::ST_OUTSIDE;
        res.cells_touched <= '0;
      end
      if (q_issue) begin
        rd_lastf <= (32'(slot) == 32'(nq) - 1);
        slot     <= slot + 1'b1;
      end
      if (rd_pend) begin
        res.found_id      <= ram_rdata;
        res.has_object    <= 1'b1;
        res.last          <= rd_lastf;
        res.status        <= qtcb_pkg::ST_OK;
        res.cells_touched <= '0;
      end
      // clear sweep
      if (cmd.clr_step) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_last) begin
          res.found_id      <= '0;
          res.has_object    <= 1'b0;
          res.last          <= 1'b1;
          res.status        <= qtcb_pkg::ST_OK;
          res.cells_touched <= '0;
        end
      end
    end
  end

  // status to controller
  always_comb begin
    stat.scan_done = (32'(sidx) == SIDE);
    stat.clr_done  = clr_last;
    if (is_add)
      stat.cell_done = add_last;
    else
      stat.cell_done = q_empty || (q_issue && (32'(slot) == 32'(nq) - 1));
  end

endmodule

>>> rtl/qtcb_ctrl.sv
// ----------------------------------------------------------------------------
// qtcb_ctrl
// Sequencer for add, query and clear: span scan, cell walk, clear sweep.
// ----------------------------------------------------------------------------
module qtcb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         op,
  input  qtcb_pkg::dp_stat_t stat,
  output qtcb_pkg::dp_cmd_t  cmd,
  output logic               busy
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_CELL, S_CLEAR, S_DRAIN
  } state_t;
  state_t state;

  logic go;
  always_comb begin
    go = start && !busy;
    cmd.load      = go;
    cmd.scan_step = (state == S_SCAN) && !stat.scan_done;
    cmd.cell_step = (state == S_CELL);
    cmd.clr_step  = (state == S_CLEAR) || (state == S_INIT);
  end

  // state and busy; reset starts with a sweep of the fill table
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      busy  <= 1'b1;
    end else begin
      unique case (state)
        S_INIT: begin
          if (stat.clr_done) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (go) begin
            unique case (op) inside
              qtcb_pkg::OP_ADD, qtcb_pkg::OP_QUERY: begin
                state <= S_SCAN;
                busy  <= 1'b1;
              end
              qtcb_pkg::OP_CLEAR: begin
                state <= S_CLEAR;
                busy  <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_SCAN:  if (stat.scan_done) state <= S_CELL;
        S_CELL:  if (stat.cell_done) state <= S_DRAIN;
        S_CLEAR: if (stat.clr_done) state <= S_DRAIN;
        S_DRAIN: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/quadtree_cell_binning.sv
// ----------------------------------------------------------------------------
// quadtree_cell_binning
// Flat quadtree of 2^LEVELS x 2^LEVELS leaf cells holding object id lists.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. After reset busy stays
// high while the fill table is swept to empty. Every add or query first scans
// the 2^LEVELS column and row spans (LEVELS capped at 5), one index per cycle.
// An add then walks all 4^LEVELS leaf cells, one per cycle, finishes the last
// update, and strobes one result in the following cycle, with busy dropping in
// the cycle after that. A query reads one id per cycle from the id memory and
// strobes one result per cycle, at most CELL_CAPACITY of them (capped at 32);
// the last one shows in the first cycle with busy low. An empty or outside
// query strobes a single result. A clear sweeps the fill table, one cell a
// cycle, and then strobes its result. Results appear on result for one cycle
// with result_valid high; the receiver cannot stall.
module quadtree_cell_binning #(
  parameter int LEVELS        = 3,
  parameter int CELL_CAPACITY = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  qtcb_pkg::item_t     item,
  output logic                result_valid,
  output qtcb_pkg::result_t   result,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  qtcb_pkg::dp_cmd_t  cmd;
  qtcb_pkg::dp_stat_t stat;

  qtcb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (item.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  qtcb_datapath #(
    .LEVELS        (LEVELS),
    .CELL_CAPACITY (CELL_CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (result_valid),
    .res       (result)
  );

endmodule
